// ----- rtl/lssc_pkg.sv -----
// Shared constants, register indexes and types for the line sensor smoothing classifier.
// Used by lssc_div, lssc_ema and line_sensor_smooth_classify_top; no dependencies.
package lssc_pkg;

   // Default field geometry
   localparam int RAW_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF = 16;

   // Fixed widths of ports and registers
   localparam int FIELD_BITS     = 16;
   localparam int GAIN_BITS      = 16;
   localparam int LEVEL_BITS     = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;
   localparam int POSE_BITS      = 2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_MIN       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_MAX       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT_MIN      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT_MAX      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING_GAIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DETECT_LEVEL   = 3'd5;

   // Register reset values
   localparam logic [FIELD_BITS-1:0] LEFT_MIN_RST  = 16'd0;
   localparam logic [FIELD_BITS-1:0] LEFT_MAX_RST  = 16'd65535;
   localparam logic [FIELD_BITS-1:0] RIGHT_MIN_RST = 16'd0;
   localparam logic [FIELD_BITS-1:0] RIGHT_MAX_RST = 16'd65535;
   localparam logic [GAIN_BITS-1:0]  GAIN_RST      = 16'd22938;  // 0.35 in Q0.16
   localparam logic [LEVEL_BITS-1:0] LEVEL_RST     = 17'd32768;  // 0.5 in Q1.16

   // Item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NORM,
      ST_SMOOTH,
      ST_CLASSIFY
   } state_type;

   // Outcome of the range checks ahead of the division
   typedef enum logic [1:0] {
      NK_DIVIDE,
      NK_ZERO,
      NK_FULL
   } norm_kind_type;

endpackage

// ----- rtl/line_sensor_smooth_classify_top.sv -----
// Top level of the two-channel line sensor: config registers, sequencer, output register.
// Depends on lssc_pkg, lssc_div and lssc_ema.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_command, req_left_raw, req_right_raw
//   rsp       out        rsp_valid/rsp_ready   rsp_pose
//   csr       in         csr_wr_en             csr_index, csr_wdata
//
// A sample item's time is set by the bit-serial dividers (one quotient bit per cycle), and
// a tick's by the shift-add multipliers over the 16 gain bits; the first tick after reset
// skips the multipliers and goes straight to classification.
// One item is worked at a time; req_ready is high only while the sequencer is idle.
// A finished pose sits in the output register; the next item is accepted while it waits,
// and only a following tick stalls until rsp_ready frees the register.
// Reset (synchronous) restores the register defaults and clears averages and fractions.
module line_sensor_smooth_classify_top #(
   parameter int RAW_BITS  = lssc_pkg::RAW_BITS_DEF,
   parameter int FRAC_BITS = lssc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [lssc_pkg::FIELD_BITS-1:0]     req_left_raw,
   input  logic [lssc_pkg::FIELD_BITS-1:0]     req_right_raw,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lssc_pkg::POSE_BITS-1:0]      rsp_pose,
   input  logic                                csr_wr_en,
   input  logic [lssc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lssc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int FB = lssc_pkg::FIELD_BITS;
   localparam int LW = lssc_pkg::LEVEL_BITS + FRAC_BITS;
   localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

   // Configuration registers
   logic [FB-1:0]                     left_min_ff, left_max_ff, right_min_ff, right_max_ff;
   logic [lssc_pkg::GAIN_BITS-1:0]    gain_ff;
   logic [lssc_pkg::LEVEL_BITS-1:0]   level_ff;

   // Control and state
   lssc_pkg::state_type               state_ff, state_in;
   logic [FRAC_BITS:0]                left_norm_ff, right_norm_ff;
   logic [FRAC_BITS:0]                left_smooth_ff, right_smooth_ff;
   logic                              first_tick_ff;
   logic                              rsp_valid_ff;
   logic [lssc_pkg::POSE_BITS-1:0]    rsp_pose_ff;

   logic                              accept;
   logic                              div_start, ema_start, load_out;
   logic                              left_div_done, right_div_done;
   logic                              left_ema_done, right_ema_done;
   logic [FRAC_BITS:0]                left_div_norm, right_div_norm;
   logic [FRAC_BITS:0]                left_ema_res, right_ema_res;
   logic [LW-1:0]                     level_wide;
   logic [FRAC_BITS:0]                level;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_min_ff  <= lssc_pkg::LEFT_MIN_RST;
         left_max_ff  <= lssc_pkg::LEFT_MAX_RST;
         right_min_ff <= lssc_pkg::RIGHT_MIN_RST;
         right_max_ff <= lssc_pkg::RIGHT_MAX_RST;
         gain_ff      <= lssc_pkg::GAIN_RST;
         level_ff     <= lssc_pkg::LEVEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lssc_pkg::REG_LEFT_MIN:       left_min_ff  <= csr_wdata[FB-1:0];
            lssc_pkg::REG_LEFT_MAX:       left_max_ff  <= csr_wdata[FB-1:0];
            lssc_pkg::REG_RIGHT_MIN:      right_min_ff <= csr_wdata[FB-1:0];
            lssc_pkg::REG_RIGHT_MAX:      right_max_ff <= csr_wdata[FB-1:0];
            lssc_pkg::REG_SMOOTHING_GAIN: gain_ff      <= csr_wdata[lssc_pkg::GAIN_BITS-1:0];
            lssc_pkg::REG_DETECT_LEVEL:   level_ff     <= csr_wdata[lssc_pkg::LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and unit starts
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      ema_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         lssc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_command == lssc_pkg::CMD_SAMPLE) begin
                  div_start = 1'b1;
                  state_in  = lssc_pkg::ST_NORM;
               end else if (first_tick_ff) begin
                  state_in  = lssc_pkg::ST_CLASSIFY;
               end else begin
                  ema_start = 1'b1;
                  state_in  = lssc_pkg::ST_SMOOTH;
               end
            end
         end
         lssc_pkg::ST_NORM: begin
            if (left_div_done) state_in = lssc_pkg::ST_IDLE;
         end
         lssc_pkg::ST_SMOOTH: begin
            if (left_ema_done) state_in = lssc_pkg::ST_CLASSIFY;
         end
         lssc_pkg::ST_CLASSIFY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = lssc_pkg::ST_IDLE;
            end
         end
         default: state_in = lssc_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == lssc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lssc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Stored fractions, averages and first-tick flag
   always_ff @(posedge clock) begin
      if (reset) begin
         left_norm_ff    <= '0;
         right_norm_ff   <= '0;
         left_smooth_ff  <= '0;
         right_smooth_ff <= '0;
         first_tick_ff   <= 1'b1;
      end else begin
         if (state_ff == lssc_pkg::ST_NORM && left_div_done) begin
            left_norm_ff  <= left_div_norm;
            right_norm_ff <= right_div_norm;
         end
         if (accept && req_command == lssc_pkg::CMD_TICK && first_tick_ff) begin
            left_smooth_ff  <= left_norm_ff;
            right_smooth_ff <= right_norm_ff;
            first_tick_ff   <= 1'b0;
         end
         if (state_ff == lssc_pkg::ST_SMOOTH && left_ema_done) begin
            left_smooth_ff  <= left_ema_res;
            right_smooth_ff <= right_ema_res;
         end
      end
   end

   // Normalizers, one per channel
   lssc_div #(.RAW_BITS(RAW_BITS), .FRAC_BITS(FRAC_BITS)) u_left_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .raw   (req_left_raw[RAW_BITS-1:0]),
      .lo    (left_min_ff[RAW_BITS-1:0]),
      .hi    (left_max_ff[RAW_BITS-1:0]),
      .done  (left_div_done),
      .norm  (left_div_norm)
   );

   lssc_div #(.RAW_BITS(RAW_BITS), .FRAC_BITS(FRAC_BITS)) u_right_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .raw   (req_right_raw[RAW_BITS-1:0]),
      .lo    (right_min_ff[RAW_BITS-1:0]),
      .hi    (right_max_ff[RAW_BITS-1:0]),
      .done  (right_div_done),
      .norm  (right_div_norm)
   );

   // Moving averages, one per channel
   lssc_ema #(.FRAC_BITS(FRAC_BITS)) u_left_ema (
      .clock  (clock),
      .reset  (reset),
      .start  (ema_start),
      .gain   (gain_ff),
      .smooth (left_smooth_ff),
      .norm   (left_norm_ff),
      .done   (left_ema_done),
      .result (left_ema_res)
   );

   lssc_ema #(.FRAC_BITS(FRAC_BITS)) u_right_ema (
      .clock  (clock),
      .reset  (reset),
      .start  (ema_start),
      .gain   (gain_ff),
      .smooth (right_smooth_ff),
      .norm   (right_norm_ff),
      .done   (right_ema_done),
      .result (right_ema_res)
   );

   // Threshold aligned to the fraction width
   assign level_wide = (LW'(level_ff) << UP) >> DN;
   assign level      = level_wide[FRAC_BITS:0];

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_pose_ff <= {right_smooth_ff > level, left_smooth_ff > level};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pose  = rsp_pose_ff;

   // Checks
   a_div_in_norm: assert property (@(posedge clock) disable iff (reset)
      left_div_done |-> (state_ff == lssc_pkg::ST_NORM && right_div_done))
      else $error("divider finished outside normalize state or channels out of step");

   a_ema_in_smooth: assert property (@(posedge clock) disable iff (reset)
      left_ema_done |-> (state_ff == lssc_pkg::ST_SMOOTH && right_ema_done))
      else $error("average finished outside smooth state or channels out of step");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("loaded pose not presented");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_smooth_ff <= {1'b1, {FRAC_BITS{1'b0}}})
      else $error("left average above 1.0");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      right_smooth_ff <= {1'b1, {FRAC_BITS{1'b0}}})
      else $error("right average above 1.0");

endmodule

// ----- rtl/lssc_div.sv -----
// Bit-serial restoring divider that scales one raw reading into a Q1.FRAC_BITS fraction.
// Depends on lssc_pkg; one quotient bit per cycle.
module lssc_div #(
   parameter int RAW_BITS  = lssc_pkg::RAW_BITS_DEF,
   parameter int FRAC_BITS = lssc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAW_BITS-1:0]  raw,
   input  logic [RAW_BITS-1:0]  lo,
   input  logic [RAW_BITS-1:0]  hi,
   output logic                 done,
   output logic [FRAC_BITS:0]   norm
);

   localparam int CW = $clog2(FRAC_BITS);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [RAW_BITS:0]            rem_ff, rem_in;
   logic [RAW_BITS-1:0]          den_ff, den_in;
   logic [FRAC_BITS-1:0]         quot_ff, quot_in;
   lssc_pkg::norm_kind_type      kind_ff, kind_in;

   logic [RAW_BITS:0]            rem_dbl;
   logic                         fits;

   // One restoring step: double the remainder, subtract the span when it fits
   assign rem_dbl = {rem_ff[RAW_BITS-1:0], 1'b0};
   assign fits    = rem_dbl >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      kind_in = kind_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         den_in  = hi - lo;
         rem_in  = {1'b0, raw - lo};
         quot_in = '0;
         if (hi <= lo || raw <= lo) begin
            kind_in = lssc_pkg::NK_ZERO;
         end else if (raw >= hi) begin
            kind_in = lssc_pkg::NK_FULL;
         end else begin
            kind_in = lssc_pkg::NK_DIVIDE;
         end
      end else if (run_ff) begin
         rem_in  = fits ? (rem_dbl - {1'b0, den_ff}) : rem_dbl;
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath needs no reset
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      kind_ff <= kind_in;
   end

   // Result selection, valid while done is high
   always_comb begin
      case (kind_ff)
         lssc_pkg::NK_ZERO:   norm = '0;
         lssc_pkg::NK_FULL:   norm = {1'b1, {FRAC_BITS{1'b0}}};
         lssc_pkg::NK_DIVIDE: norm = {1'b0, quot_ff};
         default:             norm = '0;
      endcase
   end

   assign done = done_ff;

endmodule

// ----- rtl/lssc_ema.sv -----
// Moving average step with a bit-serial shift-add multiplier over the gain bits.
// Depends on lssc_pkg; truncated step toward zero.
module lssc_ema #(
   parameter int FRAC_BITS = lssc_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lssc_pkg::GAIN_BITS-1:0] gain,
   input  logic [FRAC_BITS:0]             smooth,
   input  logic [FRAC_BITS:0]             norm,
   output logic                           done,
   output logic [FRAC_BITS:0]             result
);

   localparam int GB = lssc_pkg::GAIN_BITS;
   localparam int CW = $clog2(GB);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [GB-1:0]        gain_ff, gain_in;
   logic [FRAC_BITS:0]   acc_ff, acc_in;
   logic [FRAC_BITS:0]   diff_ff, diff_in;
   logic [FRAC_BITS:0]   base_ff, base_in;
   logic                 up_ff, up_in;

   logic [FRAC_BITS+1:0] acc_sum;

   // Add the partial product for this gain bit, then halve (floor)
   assign acc_sum = {1'b0, acc_ff} + (gain_ff[0] ? {1'b0, diff_ff} : '0);

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      gain_in = gain_ff;
      acc_in  = acc_ff;
      diff_in = diff_ff;
      base_in = base_ff;
      up_in   = up_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         gain_in = gain;
         acc_in  = '0;
         base_in = smooth;
         up_in   = norm >= smooth;
         diff_in = (norm >= smooth) ? (norm - smooth) : (smooth - norm);
      end else if (run_ff) begin
         acc_in  = acc_sum[FRAC_BITS+1:1];
         gain_in = {1'b0, gain_ff[GB-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(GB - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
      acc_ff  <= acc_in;
      diff_ff <= diff_in;
      base_ff <= base_in;
      up_ff   <= up_in;
   end

   // Step stays between old average and new fraction, so no overflow
   assign result = up_ff ? (base_ff + acc_ff) : (base_ff - acc_ff);
   assign done   = done_ff;

endmodule

// ----- verif/line_sensor_smooth_classify_top_tb.sv -----
// Self-checking testbench for line_sensor_smooth_classify_top: sample and tick items with
// random pacing, pose results checked against an in-bench normalize/average/threshold model.
// Depends on lssc_pkg and the line_sensor_smooth_classify_top RTL.
module line_sensor_smooth_classify_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_BITS     = lssc_pkg::FIELD_BITS;
   localparam int GAIN_BITS      = lssc_pkg::GAIN_BITS;
   localparam int LEVEL_BITS     = lssc_pkg::LEVEL_BITS;
   localparam int CSR_INDEX_BITS = lssc_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = lssc_pkg::CSR_DATA_BITS;
   localparam int POSE_BITS      = lssc_pkg::POSE_BITS;

   localparam int DRAIN_CYCLES   = 40;    // about twice the time of the slowest item, a tick
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 140;
   localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 17'h10000;  // 1.0 in Q1.16

   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pacing_type;

   typedef struct {
      logic                  command;
      logic [FIELD_BITS-1:0] left_raw;
      logic [FIELD_BITS-1:0] right_raw;
   } sensor_item_type;

   // DUT ports; the inputs driven here are known from time zero
   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   logic                      req_command   = lssc_pkg::CMD_SAMPLE;
   logic [FIELD_BITS-1:0]     req_left_raw  = '0;
   logic [FIELD_BITS-1:0]     req_right_raw = '0;
   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   logic [POSE_BITS-1:0]      rsp_pose;
   logic                      csr_wr_en     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = lssc_pkg::REG_LEFT_MIN;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;

   // Register copies as the block should hold them
   logic [FIELD_BITS-1:0] cfg_left_min     = lssc_pkg::LEFT_MIN_RST;
   logic [FIELD_BITS-1:0] cfg_left_max     = lssc_pkg::LEFT_MAX_RST;
   logic [FIELD_BITS-1:0] cfg_right_min    = lssc_pkg::RIGHT_MIN_RST;
   logic [FIELD_BITS-1:0] cfg_right_max    = lssc_pkg::RIGHT_MAX_RST;
   logic [GAIN_BITS-1:0]  cfg_gain         = lssc_pkg::GAIN_RST;
   logic [LEVEL_BITS-1:0] cfg_detect_level = lssc_pkg::LEVEL_RST;

   // Fractions and averages, Q1.16
   logic [LEVEL_BITS-1:0] left_frac          = '0;
   logic [LEVEL_BITS-1:0] right_frac         = '0;
   logic [LEVEL_BITS-1:0] left_avg           = '0;
   logic [LEVEL_BITS-1:0] right_avg          = '0;
   logic                  awaiting_first_tick = 1'b1;

   sensor_item_type      pending_items[$];
   sensor_item_type      held_item;
   logic [POSE_BITS-1:0] pose_expected[$];
   int unsigned          pushed_count       = 0;
   int unsigned          accepted_count     = 0;
   int unsigned          error_count        = 0;
   int unsigned          sender_idle_pct    = 0;
   int unsigned          receiver_stall_pct = 0;
   int unsigned          idle_cycles        = 0;

   line_sensor_smooth_classify_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_left_raw  (req_left_raw),
      .req_right_raw (req_right_raw),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pose      (rsp_pose),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Reading scaled into [0, 1.0]; empty or inverted calibration gives 0
   function automatic logic [LEVEL_BITS-1:0] normalize_reading(
      input logic [FIELD_BITS-1:0] raw,
      input logic [FIELD_BITS-1:0] lo,
      input logic [FIELD_BITS-1:0] hi
   );
      logic [32:0] scaled;
      if (hi <= lo || raw <= lo) return '0;
      if (raw >= hi) return FULL_SCALE;
      scaled = 33'(raw - lo) << 16;
      scaled = scaled / 33'(hi - lo);
      return scaled[LEVEL_BITS-1:0];
   endfunction

   // One moving-average step; the step magnitude truncates toward zero
   function automatic logic [LEVEL_BITS-1:0] smooth_step(
      input logic [LEVEL_BITS-1:0] avg,
      input logic [LEVEL_BITS-1:0] frac,
      input logic [GAIN_BITS-1:0]  gain
   );
      logic [32:0] product;
      if (frac >= avg) begin
         product = 33'(gain) * 33'(frac - avg);
         return avg + product[32:16];
      end
      product = 33'(gain) * 33'(avg - frac);
      return avg - product[32:16];
   endfunction

   // Raw value biased toward the calibration window and its edges
   function automatic logic [FIELD_BITS-1:0] pick_raw(
      input logic [FIELD_BITS-1:0] lo,
      input logic [FIELD_BITS-1:0] hi
   );
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) return FIELD_BITS'($urandom_range(65535));
      if (roll < 70 && lo < hi) return FIELD_BITS'($urandom_range(hi, lo));
      case ($urandom_range(5))
         0: return lo;
         1: return lo + 1'b1;
         2: return hi;
         3: return hi - 1'b1;
         4: return '0;
         default: return '1;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic push_item(
      input logic                  command,
      input logic [FIELD_BITS-1:0] left_raw,
      input logic [FIELD_BITS-1:0] right_raw
   );
      sensor_item_type item;
      item.command   = command;
      item.left_raw  = left_raw;
      item.right_raw = right_raw;
      pending_items.push_back(item);
      pushed_count++;
   endtask

   task automatic set_pacing(input pacing_type pace);
      case (pace)
         PACE_STEADY: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         PACE_SENDER_GAPS: begin
            sender_idle_pct    = 51;
            receiver_stall_pct = 0;
         end
         PACE_RECEIVER_STALLS: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 51;
         end
         default: begin
            sender_idle_pct    = 18;
            receiver_stall_pct = 18;
         end
      endcase
   endtask

   // Everything accepted, every pose back, then room for a sample still in the divider
   task automatic wait_until_quiet();
      while (accepted_count != pushed_count || pose_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(
      input logic [CSR_INDEX_BITS-1:0] index,
      input logic [CSR_DATA_BITS-1:0]  value
   );
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         lssc_pkg::REG_LEFT_MIN:       cfg_left_min     = value[FIELD_BITS-1:0];
         lssc_pkg::REG_LEFT_MAX:       cfg_left_max     = value[FIELD_BITS-1:0];
         lssc_pkg::REG_RIGHT_MIN:      cfg_right_min    = value[FIELD_BITS-1:0];
         lssc_pkg::REG_RIGHT_MAX:      cfg_right_max    = value[FIELD_BITS-1:0];
         lssc_pkg::REG_SMOOTHING_GAIN: cfg_gain         = value[GAIN_BITS-1:0];
         lssc_pkg::REG_DETECT_LEVEL:   cfg_detect_level = value[LEVEL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(
      input logic [FIELD_BITS-1:0] lmin,
      input logic [FIELD_BITS-1:0] lmax,
      input logic [FIELD_BITS-1:0] rmin,
      input logic [FIELD_BITS-1:0] rmax,
      input logic [GAIN_BITS-1:0]  gain,
      input logic [LEVEL_BITS-1:0] level
   );
      write_csr(lssc_pkg::REG_LEFT_MIN, CSR_DATA_BITS'(lmin));
      write_csr(lssc_pkg::REG_LEFT_MAX, CSR_DATA_BITS'(lmax));
      write_csr(lssc_pkg::REG_RIGHT_MIN, CSR_DATA_BITS'(rmin));
      write_csr(lssc_pkg::REG_RIGHT_MAX, CSR_DATA_BITS'(rmax));
      write_csr(lssc_pkg::REG_SMOOTHING_GAIN, CSR_DATA_BITS'(gain));
      write_csr(lssc_pkg::REG_DETECT_LEVEL, CSR_DATA_BITS'(level));
   endtask

   // Random calibration, mostly ordered windows, sometimes inverted
   task automatic configure_random();
      logic [FIELD_BITS-1:0] a, b, c, d;
      a = FIELD_BITS'($urandom_range(65535));
      b = FIELD_BITS'($urandom_range(65535));
      c = FIELD_BITS'($urandom_range(65535));
      d = FIELD_BITS'($urandom_range(65535));
      if ($urandom_range(9) != 0 && a > b) {a, b} = {b, a};
      if ($urandom_range(9) != 0 && c > d) {c, d} = {d, c};
      configure(a, b, c, d, GAIN_BITS'($urandom_range(65535)),
                LEVEL_BITS'($urandom_range(65536)));
   endtask

   // Random samples and ticks; the sender stops halfway until all poses are back
   task automatic run_random_items(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == count / 2) wait_until_quiet();
         if ($urandom_range(99) < 40)
            push_item(lssc_pkg::CMD_TICK, FIELD_BITS'($urandom_range(65535)),
                      FIELD_BITS'($urandom_range(65535)));
         else
            push_item(lssc_pkg::CMD_SAMPLE, pick_raw(cfg_left_min, cfg_left_max),
                      pick_raw(cfg_right_min, cfg_right_max));
      end
      wait_until_quiet();
   endtask

   // Stimulus sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items under reset calibration
      set_pacing(PACE_STEADY);
      push_item(lssc_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);    // tick before any sample
      push_item(lssc_pkg::CMD_SAMPLE, 16'hFFFF, 16'h0000);  // full scale left, zero right
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_SAMPLE, 16'h0000, 16'hFFFF);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_SAMPLE, 16'h8000, 16'h7FFF);  // right at the threshold
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_SAMPLE, 16'h0001, 16'hFFFE);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_SAMPLE, 16'hAAAA, 16'h5555);  // overwritten before the tick
      push_item(lssc_pkg::CMD_SAMPLE, 16'h5555, 16'hAAAA);
      push_item(lssc_pkg::CMD_TICK, 16'h0000, 16'h0000);
      push_item(lssc_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
      wait_until_quiet();
      run_random_items(PHASE_ITEMS);

      // Calibration and pacing phases, extremes first
      for (int phase = 1; phase <= 7; phase++) begin
         case (phase)
            1: begin
               set_pacing(PACE_SENDER_GAPS);
               configure(16'd1000, 16'd60000, 16'd500, 16'd40000, 16'hFFFF, FULL_SCALE);
            end
            2: begin
               set_pacing(PACE_RECEIVER_STALLS);
               configure(16'd60000, 16'd1000, 16'd0, 16'hFFFF, 16'd0, 17'd0);
            end
            3: begin
               set_pacing(PACE_BOTH);
               configure(16'd0, 16'hFFFF, 16'd300, 16'd300, 16'hFFFF, 17'd1);
            end
            4: begin
               set_pacing(PACE_BOTH);
               configure_random();
            end
            5: begin
               set_pacing(PACE_STEADY);
               configure(16'd0, 16'd1, 16'hFFFE, 16'hFFFF, 16'h8000, 17'hFFFF);
            end
            6: begin
               set_pacing(PACE_SENDER_GAPS);
               configure_random();
            end
            default: begin
               set_pacing(PACE_RECEIVER_STALLS);
               configure_random();
            end
         endcase
         run_random_items(PHASE_ITEMS);
      end

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Request driver; predicts the pose of each accepted tick
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_count++;
            if (held_item.command == lssc_pkg::CMD_SAMPLE) begin
               left_frac  = normalize_reading(held_item.left_raw, cfg_left_min, cfg_left_max);
               right_frac = normalize_reading(held_item.right_raw, cfg_right_min,
                                              cfg_right_max);
            end else begin
               if (awaiting_first_tick) begin
                  left_avg            = left_frac;
                  right_avg           = right_frac;
                  awaiting_first_tick = 1'b0;
               end else begin
                  left_avg  = smooth_step(left_avg, left_frac, cfg_gain);
                  right_avg = smooth_step(right_avg, right_frac, cfg_gain);
               end
               pose_expected.push_back({right_avg > cfg_detect_level,
                                        left_avg > cfg_detect_level});
            end
         end
         // Hold a waiting item; otherwise offer the next one or idle
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               held_item = pending_items.pop_front();
               req_valid     <= 1'b1;
               req_command   <= held_item.command;
               req_left_raw  <= held_item.left_raw;
               req_right_raw <= held_item.right_raw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Pose monitor with random back-pressure
   always @(posedge clock) begin : pose_monitor
      logic [POSE_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_expected.size() == 0) begin
            report_mismatch($sformatf("pose %0d with no tick outstanding", rsp_pose));
         end else begin
            want = pose_expected.pop_front();
            if (rsp_pose !== want)
               report_mismatch($sformatf("pose %0d, expected %0d", rsp_pose, want));
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT at %0t ns: no item moved for %0d cycles", $time, idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
